// ===== sv/ufr_pkg.sv =====
// ----------------------------------------------------------------------------
// ufr_pkg: shared types and constants for the frame receiver
// Field widths, header constants, status and register codes, control structs.
// ----------------------------------------------------------------------------
package ufr_pkg;

    localparam int STORE_DEPTH_DEF = 256;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 9;
    localparam int TOTAL_W = 17;
    localparam int CFG_W   = 9;

    localparam logic [BYTE_W-1:0]  SYNC_BYTE    = 8'hAA;
    localparam logic [BYTE_W-1:0]  READ_FUNC    = 8'h03;
    localparam logic [TOTAL_W-1:0] LEN_OVH_HDR  = 17'd6;
    localparam logic [TOTAL_W-1:0] LEN_OVH_ADDR = 17'd5;
    localparam logic [TOTAL_W-1:0] MIN_LEN      = 17'd6;

    localparam logic ACT_RX   = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef enum logic [1:0] {
        ST_KEPT = 2'd0,
        ST_DONE = 2'd1,
        ST_DROP = 2'd2,
        ST_READ = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        MODE_HDR  = 2'd0,
        MODE_ADDR = 2'd1,
        MODE_RAW  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        CFG_FRAME_MODE   = 2'd0,
        CFG_STATION_ADDR = 2'd1,
        CFG_MAX_LEN      = 2'd2,
        CFG_BUF_LIMIT    = 2'd3
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] MAX_LEN_RST   = 9'd256;
    localparam logic [CFG_W-1:0] BUF_LIMIT_RST = 9'd256;

    typedef struct packed {
        logic [1:0]        frame_mode;
        logic [BYTE_W-1:0] station_address;
        logic [CFG_W-1:0]  max_frame_len;
        logic [CFG_W-1:0]  buffer_limit;
    } t_cfg;

    typedef struct packed {
        logic               wr_en;
        logic [COUNT_W-1:0] wr_pos;
        t_status            status;
        logic [COUNT_W-1:0] fill;
        logic [TOTAL_W-1:0] total;
    } t_rx_info;

endpackage

// ===== sv/ufr_in_if.sv =====
// ----------------------------------------------------------------------------
// ufr_in_if: request channel of the frame receiver
// Receive or read request with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ufr_in_if;
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic [ufr_pkg::BYTE_W-1:0] rx_byte;
    logic [ufr_pkg::BYTE_W-1:0] read_index;

    modport source (output valid, action, rx_byte, read_index, input ready);
    modport sink   (input valid, action, rx_byte, read_index, output ready);
endinterface

// ===== sv/ufr_out_if.sv =====
// ----------------------------------------------------------------------------
// ufr_out_if: result channel of the frame receiver
// Status, fill count, expected length and read data with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ufr_out_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [ufr_pkg::COUNT_W-1:0] fill_count;
    logic [ufr_pkg::TOTAL_W-1:0] frame_total;
    logic [ufr_pkg::BYTE_W-1:0]  read_data;

    modport source (output valid, status, fill_count, frame_total, read_data, input ready);
    modport sink   (input valid, status, fill_count, frame_total, read_data, output ready);
endinterface

// ===== sv/ufr_frame_ctrl.sv =====
// ----------------------------------------------------------------------------
// ufr_frame_ctrl: byte count and header checks
// Holds the byte count, expected length and header byte copies; decides the
// status and store write for each received byte combinationally.
// ----------------------------------------------------------------------------
module ufr_frame_ctrl #(
    parameter int STORE_DEPTH = ufr_pkg::STORE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ufr_pkg::t_cfg               i_cfg,
    input  logic                        i_rx_en,
    input  logic [ufr_pkg::BYTE_W-1:0]  i_rx_byte,
    output ufr_pkg::t_rx_info           o_info
);

    logic [ufr_pkg::COUNT_W-1:0] r_count;
    logic [ufr_pkg::COUNT_W-1:0] n_count;
    logic [ufr_pkg::TOTAL_W-1:0] r_exp;
    logic [ufr_pkg::TOTAL_W-1:0] n_exp;
    logic [ufr_pkg::BYTE_W-1:0]  r_h0;
    logic [ufr_pkg::BYTE_W-1:0]  r_h1;
    logic [ufr_pkg::BYTE_W-1:0]  r_h2;

    logic [ufr_pkg::COUNT_W-1:0] lim;
    logic [ufr_pkg::COUNT_W-1:0] cnt_inc;
    logic [ufr_pkg::TOTAL_W-1:0] cnt_inc_w;
    logic [ufr_pkg::BYTE_W-1:0]  hdr0;
    logic [ufr_pkg::TOTAL_W-1:0] len_hdr;
    logic [ufr_pkg::TOTAL_W-1:0] len_addr;
    logic [ufr_pkg::TOTAL_W-1:0] max_len_w;
    logic                        wr_en;
    ufr_pkg::t_status            status;

    assign lim = (32'(i_cfg.buffer_limit) > STORE_DEPTH)
               ? ufr_pkg::COUNT_W'(STORE_DEPTH) : i_cfg.buffer_limit;
    assign cnt_inc   = r_count + 9'd1;
    assign cnt_inc_w = ufr_pkg::TOTAL_W'(cnt_inc);
    assign hdr0      = (r_count == '0) ? i_rx_byte : r_h0;
    // byte 2 is already held when byte 3 arrives
    assign len_hdr   = ufr_pkg::TOTAL_W'({r_h2, i_rx_byte}) + ufr_pkg::LEN_OVH_HDR;
    assign len_addr  = ufr_pkg::TOTAL_W'(i_rx_byte) + ufr_pkg::LEN_OVH_ADDR;
    assign max_len_w = ufr_pkg::TOTAL_W'(i_cfg.max_frame_len);

    always_comb begin
        n_count = r_count;
        n_exp   = r_exp;
        wr_en   = 1'b0;
        status  = ufr_pkg::ST_KEPT;
        if (i_rx_en) begin
            if (r_count >= lim) begin
                n_count = '0;
                status  = ufr_pkg::ST_DROP;
            end else begin
                wr_en = 1'b1;
                case (i_cfg.frame_mode)
                    ufr_pkg::MODE_HDR: begin
                        if (hdr0 != ufr_pkg::SYNC_BYTE) begin
                            n_count = '0;
                            status  = ufr_pkg::ST_DROP;
                        end else if (cnt_inc == 9'd4) begin
                            n_exp = len_hdr;
                            if (len_hdr > max_len_w) begin
                                n_count = '0;
                                status  = ufr_pkg::ST_DROP;
                            end else begin
                                n_count = cnt_inc;
                            end
                        end else if (cnt_inc_w == r_exp && r_exp > ufr_pkg::MIN_LEN) begin
                            n_count = '0;
                            status  = ufr_pkg::ST_DONE;
                        end else begin
                            n_count = cnt_inc;
                        end
                    end
                    ufr_pkg::MODE_ADDR: begin
                        if (hdr0 != i_cfg.station_address) begin
                            n_count = '0;
                            status  = ufr_pkg::ST_DROP;
                        end else if (cnt_inc == 9'd3) begin
                            if (r_h1 != ufr_pkg::READ_FUNC) begin
                                n_count = '0;
                                status  = ufr_pkg::ST_DROP;
                            end else begin
                                n_exp = len_addr;
                                if (len_addr > max_len_w || len_addr <= ufr_pkg::MIN_LEN) begin
                                    n_count = '0;
                                    status  = ufr_pkg::ST_DROP;
                                end else begin
                                    n_count = cnt_inc;
                                end
                            end
                        end else if (cnt_inc_w >= r_exp && r_exp > ufr_pkg::MIN_LEN) begin
                            n_count = '0;
                            status  = ufr_pkg::ST_DONE;
                        end else begin
                            n_count = cnt_inc;
                        end
                    end
                    default: begin
                        n_count = cnt_inc;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_exp   <= '0;
        end else begin
            r_count <= n_count;
            r_exp   <= n_exp;
        end
    end

    // copies of the header bytes, kept in step with the store
    always_ff @(posedge i_clk) begin
        if (wr_en && r_count == 9'd0) begin
            r_h0 <= i_rx_byte;
        end
        if (wr_en && r_count == 9'd1) begin
            r_h1 <= i_rx_byte;
        end
        if (wr_en && r_count == 9'd2) begin
            r_h2 <= i_rx_byte;
        end
    end

    assign o_info.wr_en  = wr_en;
    assign o_info.wr_pos = r_count;
    assign o_info.status = status;
    assign o_info.fill   = n_count;
    assign o_info.total  = n_exp;

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rx_en && status == ufr_pkg::ST_DONE |=> r_count == '0)
        else $error("count not cleared after frame complete");

    a_kept_incr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rx_en && status == ufr_pkg::ST_KEPT |=> r_count == $past(r_count) + 9'd1)
        else $error("kept byte did not advance count");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rx_en |=> $stable(r_count) && $stable(r_exp))
        else $error("state changed without a receive");

endmodule

// ===== sv/uart_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// uart_frame_receiver: length prefixed frame receiver
// One request per cycle sustained while o_rsp.ready is high; each taken request
// passes stage 1 (header check and store access), then the output register.
// The rate is set by the single write port of the frame store and its
// registered read. Configuration writes are applied at once and expected only
// while no request is in flight.
// ----------------------------------------------------------------------------
module uart_frame_receiver #(
    parameter int STORE_DEPTH = ufr_pkg::STORE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    ufr_in_if.sink                     i_req,
    ufr_out_if.source                  o_rsp,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [ufr_pkg::CFG_W-1:0]  i_cfg_data
);

    localparam int AW = $clog2(STORE_DEPTH);

    ufr_pkg::t_cfg     r_cfg;
    ufr_pkg::t_rx_info info;

    logic                          accept;
    logic                          rx_en;
    logic                          rd_ok;
    logic                          s1_move;
    logic [ufr_pkg::BYTE_W-1:0]    r_mem [STORE_DEPTH];
    logic [ufr_pkg::BYTE_W-1:0]    r_mem_q;

    logic                          r_s1_vld;
    ufr_pkg::t_status              r_s1_status;
    logic [ufr_pkg::COUNT_W-1:0]   r_s1_fill;
    logic [ufr_pkg::TOTAL_W-1:0]   r_s1_total;
    logic                          r_s1_rd;

    logic                          r_out_vld;
    ufr_pkg::t_status              r_out_status;
    logic [ufr_pkg::COUNT_W-1:0]   r_out_fill;
    logic [ufr_pkg::TOTAL_W-1:0]   r_out_total;
    logic [ufr_pkg::BYTE_W-1:0]    r_out_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_mode      <= ufr_pkg::MODE_HDR;
            r_cfg.station_address <= '0;
            r_cfg.max_frame_len   <= ufr_pkg::MAX_LEN_RST;
            r_cfg.buffer_limit    <= ufr_pkg::BUF_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ufr_pkg::CFG_FRAME_MODE:   r_cfg.frame_mode      <= i_cfg_data[1:0];
                ufr_pkg::CFG_STATION_ADDR: r_cfg.station_address <= i_cfg_data[7:0];
                ufr_pkg::CFG_MAX_LEN:      r_cfg.max_frame_len   <= i_cfg_data;
                ufr_pkg::CFG_BUF_LIMIT:    r_cfg.buffer_limit    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign s1_move     = r_s1_vld && (!r_out_vld || o_rsp.ready);
    assign i_req.ready = !r_s1_vld || s1_move;
    assign accept      = i_req.valid && i_req.ready;
    assign rx_en       = accept && (i_req.action == ufr_pkg::ACT_RX);
    assign rd_ok       = 32'(i_req.read_index) < STORE_DEPTH;

    ufr_frame_ctrl #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_rx_en   (rx_en),
        .i_rx_byte (i_req.rx_byte),
        .o_info    (info)
    );

    // frame store
    always_ff @(posedge i_clk) begin
        if (info.wr_en) begin
            r_mem[AW'(info.wr_pos)] <= i_req.rx_byte;
        end
        if (accept) begin
            r_mem_q <= r_mem[AW'(i_req.read_index)];
        end
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (accept) begin
            r_s1_vld <= 1'b1;
        end else if (s1_move) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_status <= (i_req.action == ufr_pkg::ACT_READ) ? ufr_pkg::ST_READ : info.status;
            r_s1_fill   <= info.fill;
            r_s1_total  <= info.total;
            r_s1_rd     <= (i_req.action == ufr_pkg::ACT_READ) && rd_ok;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_move) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_status <= r_s1_status;
            r_out_fill   <= r_s1_fill;
            r_out_total  <= r_s1_total;
            r_out_data   <= r_s1_rd ? r_mem_q : '0;
        end
    end

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.fill_count  = r_out_fill;
    assign o_rsp.frame_total = r_out_total;
    assign o_rsp.read_data   = r_out_data;

endmodule
